// ===== hdl/gcb_pkg.sv =====
// shared types, class codes and helpers for the grapheme cluster boundary block
package gcb_pkg;

    // grapheme break classes
    typedef enum logic [3:0] {
        GC_OTHER       = 4'd0,
        GC_CR          = 4'd1,
        GC_LF          = 4'd2,
        GC_CONTROL     = 4'd3,
        GC_L           = 4'd4,
        GC_V           = 4'd5,
        GC_LV          = 4'd6,
        GC_LVT         = 4'd7,
        GC_T           = 4'd8,
        GC_PREPEND     = 4'd9,
        GC_EXTEND      = 4'd10,
        GC_ZWJ         = 4'd11,
        GC_SPACINGMARK = 4'd12,
        GC_EXTPICT     = 4'd13,
        GC_RI          = 4'd14
    } cluster_class_t;

    // indic conjunct classes
    typedef enum logic [1:0] {
        IC_NONE      = 2'd0,
        IC_CONSONANT = 2'd1,
        IC_EXTEND    = 2'd2,
        IC_LINKER    = 2'd3
    } conjunct_class_t;

    localparam int unsigned CodePointWidth = 21;
    localparam int unsigned ClassWidth     = 4;
    localparam int unsigned ConjWidth      = 2;
    localparam int unsigned InDataWidth    = 32;
    localparam int unsigned OutDataWidth   = 24;

    // flags carried by the grapheme pair rules
    typedef struct packed {
        logic in_emoji_sequence;
        logic ri_count_odd;
    } grapheme_flags_t;

    // flags carried by the indic conjunct rule
    typedef struct packed {
        logic in_conjunct_sequence;
        logic linker_seen;
    } conjunct_flags_t;

    // extend, zwj and spacing mark all glue to what precedes them
    function automatic logic is_joiner_like(input logic [ClassWidth-1:0] c);
        is_joiner_like = (c == GC_EXTEND) || (c == GC_ZWJ) || (c == GC_SPACINGMARK);
    endfunction

endpackage

// ===== hdl/gcb_grapheme_rule.sv =====
// grapheme pair table: break decision and emoji / regional indicator flag update
module gcb_grapheme_rule (
    input  logic [gcb_pkg::ClassWidth-1:0] prev_class,
    input  logic [gcb_pkg::ClassWidth-1:0] cur_class,
    input  gcb_pkg::grapheme_flags_t       flags_in,
    output logic                           allow,
    output gcb_pkg::grapheme_flags_t       flags_next
);

    logic joiner;

    assign joiner = gcb_pkg::is_joiner_like(cur_class);

    // pair lookup keyed on the previous class
    always_comb begin
        flags_next = flags_in;
        allow      = 1'b1;
        unique case (prev_class)
            gcb_pkg::GC_CR: begin
                allow = (cur_class != gcb_pkg::GC_LF);
            end
            gcb_pkg::GC_CONTROL, gcb_pkg::GC_LF: begin
                allow = 1'b1;
            end
            gcb_pkg::GC_L: begin
                allow = !((cur_class == gcb_pkg::GC_L) || (cur_class == gcb_pkg::GC_V) ||
                          (cur_class == gcb_pkg::GC_LV) || (cur_class == gcb_pkg::GC_LVT) ||
                          joiner);
            end
            gcb_pkg::GC_LV, gcb_pkg::GC_V: begin
                allow = !((cur_class == gcb_pkg::GC_V) || (cur_class == gcb_pkg::GC_T) ||
                          joiner);
            end
            gcb_pkg::GC_LVT, gcb_pkg::GC_T: begin
                allow = !((cur_class == gcb_pkg::GC_T) || joiner);
            end
            gcb_pkg::GC_PREPEND: begin
                allow = (cur_class == gcb_pkg::GC_CONTROL) || (cur_class == gcb_pkg::GC_CR) ||
                        (cur_class == gcb_pkg::GC_LF);
            end
            gcb_pkg::GC_EXTEND: begin
                if ((cur_class == gcb_pkg::GC_EXTEND) || (cur_class == gcb_pkg::GC_ZWJ)) begin
                    allow = 1'b0;
                end else begin
                    flags_next.in_emoji_sequence = 1'b0;
                    allow = (cur_class != gcb_pkg::GC_SPACINGMARK);
                end
            end
            gcb_pkg::GC_ZWJ: begin
                if (joiner) begin
                    flags_next.ri_count_odd = 1'b0;
                    allow = 1'b0;
                end else if (cur_class == gcb_pkg::GC_EXTPICT) begin
                    // emoji zwj sequence stays joined
                    allow = !flags_in.in_emoji_sequence;
                    flags_next.in_emoji_sequence = 1'b0;
                end else begin
                    flags_next.in_emoji_sequence = 1'b0;
                    allow = 1'b1;
                end
            end
            gcb_pkg::GC_EXTPICT: begin
                if (cur_class == gcb_pkg::GC_SPACINGMARK) begin
                    allow = 1'b0;
                end else if ((cur_class == gcb_pkg::GC_EXTEND) ||
                             (cur_class == gcb_pkg::GC_ZWJ)) begin
                    flags_next.in_emoji_sequence = 1'b1;
                    allow = 1'b0;
                end else begin
                    allow = 1'b1;
                end
            end
            gcb_pkg::GC_RI: begin
                if (joiner) begin
                    flags_next.ri_count_odd = 1'b0;
                    allow = 1'b0;
                end else if (cur_class == gcb_pkg::GC_RI) begin
                    // regional indicators pair up
                    allow = flags_in.ri_count_odd;
                    flags_next.ri_count_odd = !flags_in.ri_count_odd;
                end else begin
                    flags_next.ri_count_odd = 1'b0;
                    allow = 1'b1;
                end
            end
            default: begin
                allow = !joiner;
            end
        endcase
    end

endmodule

// ===== hdl/gcb_conjunct_rule.sv =====
// indic conjunct rule: break decision and sequence / linker flag update
module gcb_conjunct_rule (
    input  logic [gcb_pkg::ConjWidth-1:0] prev_class,
    input  logic [gcb_pkg::ConjWidth-1:0] cur_class,
    input  gcb_pkg::conjunct_flags_t      flags_in,
    output logic                          allow,
    output gcb_pkg::conjunct_flags_t      flags_next
);

    logic cont;

    assign cont = (cur_class == gcb_pkg::IC_EXTEND) || (cur_class == gcb_pkg::IC_LINKER);

    // flags are rebuilt from scratch for every beat
    always_comb begin
        allow = 1'b1;
        flags_next.in_conjunct_sequence = 1'b0;
        flags_next.linker_seen = 1'b0;
        unique case (prev_class)
            gcb_pkg::IC_CONSONANT: begin
                if (cont) begin
                    allow = 1'b0;
                    flags_next.in_conjunct_sequence = 1'b1;
                end
            end
            gcb_pkg::IC_EXTEND: begin
                if (cont) begin
                    allow = !flags_in.in_conjunct_sequence;
                    flags_next.in_conjunct_sequence = flags_in.in_conjunct_sequence;
                    flags_next.linker_seen = flags_in.linker_seen;
                end else if (cur_class == gcb_pkg::IC_CONSONANT) begin
                    allow = !flags_in.linker_seen;
                end
            end
            gcb_pkg::IC_LINKER: begin
                if (cont) begin
                    allow = !flags_in.in_conjunct_sequence;
                    flags_next.in_conjunct_sequence = flags_in.in_conjunct_sequence;
                    flags_next.linker_seen = flags_in.in_conjunct_sequence;
                end else if (cur_class == gcb_pkg::IC_CONSONANT) begin
                    allow = !flags_in.in_conjunct_sequence;
                end
            end
            default: begin
                allow = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/grapheme_cluster_boundary.sv =====
// top level: input register, boundary rules, running state and output register
// path: an accepted input beat passes the input register, then the output register, to its result beat on m_
// throughput: one code point per cycle while m_tready allows; the input register and the output register
// form a two-entry pipeline that advances whenever the output side is free
// reset: aresetn low clears both valid flags, the previous classes (other, none)
// and all four sequence flags; payload registers are not reset
module grapheme_cluster_boundary (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: scalar_value[20:0], cluster_class[24:21], conjunct_class[26:25], zeros
    input  logic [gcb_pkg::InDataWidth-1:0]   s_tdata,
    // s_tuser: first_of_text[0]
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: scalar_out[20:0], zeros
    output logic [gcb_pkg::OutDataWidth-1:0]  m_tdata,
    // m_tuser: starts_cluster[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    localparam int unsigned CpW = gcb_pkg::CodePointWidth;
    localparam int unsigned GcW = gcb_pkg::ClassWidth;
    localparam int unsigned IcW = gcb_pkg::ConjWidth;

    // input register
    logic                   in_valid_reg;
    logic [CpW-1:0]         in_scalar_reg;
    logic [GcW-1:0]         in_cluster_class_reg;
    logic [IcW-1:0]         in_conjunct_class_reg;
    logic                   in_first_reg;

    // running state
    logic [GcW-1:0]            prev_cluster_class_reg;
    logic [IcW-1:0]            prev_conjunct_class_reg;
    gcb_pkg::grapheme_flags_t  gflags_reg;
    gcb_pkg::grapheme_flags_t  gflags_next;
    gcb_pkg::conjunct_flags_t  cflags_reg;
    gcb_pkg::conjunct_flags_t  cflags_next;

    // output register
    logic                   out_valid_reg;
    logic [CpW-1:0]         out_scalar_reg;
    logic                   out_starts_reg;

    // rule outputs
    logic                      g_allow;
    logic                      c_allow;
    gcb_pkg::grapheme_flags_t  g_flags_rule;
    gcb_pkg::conjunct_flags_t  c_flags_rule;
    logic                      starts;

    logic advance;
    logic take_in;

    // pipeline moves when the output register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    gcb_grapheme_rule u_grapheme (
        .prev_class (prev_cluster_class_reg),
        .cur_class  (in_cluster_class_reg),
        .flags_in   (gflags_reg),
        .allow      (g_allow),
        .flags_next (g_flags_rule)
    );

    gcb_conjunct_rule u_conjunct (
        .prev_class (prev_conjunct_class_reg),
        .cur_class  (in_conjunct_class_reg),
        .flags_in   (cflags_reg),
        .allow      (c_allow),
        .flags_next (c_flags_rule)
    );

    // first code point of a text forces a boundary and clears the flags
    always_comb begin
        if (in_first_reg) begin
            starts      = 1'b1;
            gflags_next = '0;
            cflags_next = '0;
        end else begin
            starts      = g_allow && c_allow;
            gflags_next = g_flags_rule;
            cflags_next = c_flags_rule;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (take_in) begin
            in_scalar_reg         <= s_tdata[CpW-1:0];
            in_cluster_class_reg  <= s_tdata[CpW+GcW-1:CpW];
            in_conjunct_class_reg <= s_tdata[CpW+GcW+IcW-1:CpW+GcW];
            in_first_reg          <= s_tuser[0];
        end
    end

    // state update as each beat moves into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_cluster_class_reg  <= gcb_pkg::GC_OTHER;
            prev_conjunct_class_reg <= gcb_pkg::IC_NONE;
            gflags_reg              <= '0;
            cflags_reg              <= '0;
        end else if (advance && in_valid_reg) begin
            prev_cluster_class_reg  <= in_cluster_class_reg;
            prev_conjunct_class_reg <= in_conjunct_class_reg;
            gflags_reg              <= gflags_next;
            cflags_reg              <= cflags_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance && in_valid_reg) begin
            out_scalar_reg <= in_scalar_reg;
            out_starts_reg <= starts;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(gcb_pkg::OutDataWidth - CpW){1'b0}}, out_scalar_reg};
    assign m_tuser[0] = out_starts_reg;

    // a text start always yields a boundary
    a_first_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && in_first_reg) |=> out_starts_reg)
        else $error("first code point of a text did not start a cluster");

    // a text start leaves the conjunct flags clear
    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && in_first_reg) |=>
            (!cflags_reg.in_conjunct_sequence && !cflags_reg.linker_seen))
        else $error("conjunct flags not cleared at text start");

    // a linker is only remembered inside a conjunct sequence
    a_linker_in_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cflags_reg.linker_seen |-> cflags_reg.in_conjunct_sequence)
        else $error("linker flag set outside a conjunct sequence");

    // an open conjunct sequence ends on an extend or a linker
    a_seq_prev_class: assert property (@(posedge aclk) disable iff (!aresetn)
        cflags_reg.in_conjunct_sequence |->
            ((prev_conjunct_class_reg == gcb_pkg::IC_EXTEND) ||
             (prev_conjunct_class_reg == gcb_pkg::IC_LINKER)))
        else $error("conjunct sequence open after a non-continuing class");

    // code point is carried through unchanged
    a_scalar_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg) |=> (out_scalar_reg == $past(in_scalar_reg)))
        else $error("code point altered on its way through");

endmodule
